// ----- rtl/mlft_pkg.sv -----
`default_nettype none

package mlft_pkg;

    // Field widths
    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;
    localparam int MASK_W = 8;
    localparam int AGE_W  = 16;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int OP_W   = 3;

    // Parameter defaults
    localparam int DEF_NUM_PORTS   = 8;
    localparam int DEF_TABLE_DEPTH = 64;

    // Register reset value
    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd300;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DEL   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_PRESENT   = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Commands broadcast to every cell
    localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
    localparam logic [OP_W-1:0] OP_CMP  = 3'd1;
    localparam logic [OP_W-1:0] OP_SEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd5;
    localparam logic [OP_W-1:0] OP_AGE  = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] in_port;
        logic [MASK_W-1:0] link_up_mask;
        logic              entry_static;
        logic [AGE_W-1:0]  start_age;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] fwd_mask;
        logic              dest_known;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] port;
        logic              is_static;
        logic [AGE_W-1:0]  age;
        logic [AGE_W-1:0]  age_limit;
    } cell_cmd_t;

    // Summary handed from each cell to the next one up the row
    typedef struct packed {
        logic              free_seen;
        logic              src_hit;
        logic              src_static;
        logic [PORT_W-1:0] src_port;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
    } cell_chain_t;

endpackage

`default_nettype wire

// ----- rtl/mlft_cell.sv -----
`default_nettype none

module mlft_cell
    import mlft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cell_cmd_t   cmd,
    input  wire cell_chain_t chain_in,
    output cell_chain_t      chain_out
);

    logic              valid_reg, valid_next;
    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              static_reg, static_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic              hit_src_reg, hit_src_next;
    logic              hit_dst_reg, hit_dst_next;
    logic              pick_reg, pick_next;
    logic [AGE_W-1:0]  age_inc;

    assign age_inc = AGE_W'(age_reg + 1'b1);

    // Apply the broadcast command to this entry
    always_comb
    begin
        valid_next   = valid_reg;
        mac_next     = mac_reg;
        port_next    = port_reg;
        static_next  = static_reg;
        age_next     = age_reg;
        hit_src_next = hit_src_reg;
        hit_dst_next = hit_dst_reg;
        pick_next    = pick_reg;
        unique case (cmd.op)
            OP_CMP:
            begin
                hit_src_next = valid_reg && (mac_reg == cmd.src_mac);
                hit_dst_next = valid_reg && (mac_reg == cmd.dst_mac);
            end
            OP_SEL:
            begin
                pick_next = !valid_reg && !chain_in.free_seen;
            end
            OP_ADD:
            begin
                if (pick_reg)
                begin
                    valid_next  = 1'b1;
                    mac_next    = cmd.src_mac;
                    port_next   = cmd.port;
                    static_next = cmd.is_static;
                    age_next    = cmd.age;
                end
            end
            OP_MOVE:
            begin
                if (hit_src_reg && !static_reg)
                    port_next = cmd.port;
            end
            OP_DEL:
            begin
                if (hit_src_reg)
                    valid_next = 1'b0;
            end
            OP_AGE:
            begin
                if (valid_reg)
                begin
                    age_next = age_inc;
                    if (age_inc == cmd.age_limit)
                        valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            hit_src_reg <= 1'b0;
            hit_dst_reg <= 1'b0;
            pick_reg    <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            hit_src_reg <= hit_src_next;
            hit_dst_reg <= hit_dst_next;
            pick_reg    <= pick_next;
        end
    end

    // Hold the entry payload
    always_ff @(posedge clk)
    begin
        mac_reg    <= mac_next;
        port_reg   <= port_next;
        static_reg <= static_next;
        age_reg    <= age_next;
    end

    // Fold this entry into the summary passed to the neighbour
    always_comb
    begin
        chain_out.free_seen  = chain_in.free_seen | !valid_reg;
        chain_out.src_hit    = chain_in.src_hit | hit_src_reg;
        chain_out.src_static = chain_in.src_static | (hit_src_reg & static_reg);
        chain_out.src_port   = chain_in.src_port | (hit_src_reg ? port_reg : '0);
        chain_out.dst_hit    = chain_in.dst_hit | hit_dst_reg;
        chain_out.dst_port   = chain_in.dst_port | (hit_dst_reg ? port_reg : '0);
    end

endmodule

`default_nettype wire

// ----- rtl/mac_learning_forwarding_table_core.sv -----
// Address table of a learning Ethernet switch, built as a row of entry cells.
// Input channel in_valid/in_ready carries one item_t per transaction: a frame
// (learn source, look up destination), an aging tick, an entry add or an
// entry delete. Output channel out_valid/out_ready returns one result_t per
// item, in order. cfg_valid/cfg_ready writes age_limit; write it only while
// no item is in flight.
// Each item passes through these steps in order: accept, compare in all cells, fold
// the cell summaries along the row and pick the lowest free slot, then update
// the cells and register the result, which is offered from the output register.
// The fold along the row of TABLE_DEPTH cells sets the length of the
// selection cycle. One item is in flight at a time, so a new item is taken
// only after the update of the last one.
// The result sits in an output register; the next item is accepted and
// worked on while it waits, and only the update cycle holds while the
// receiver stalls with a result still unread.
// Reset empties the table at once (all valid bits cleared) and sets
// age_limit to 300; the block takes items from the first cycle after reset.
`default_nettype none

module mac_learning_forwarding_table_core
    import mlft_pkg::*;
#(
    parameter int NUM_PORTS   = DEF_NUM_PORTS,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire item_t            in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [AGE_W-1:0] cfg_data
);

    localparam logic [MASK_W-1:0] FLOOD_ALL =
        (NUM_PORTS >= MASK_W) ? '1 : MASK_W'((1 << NUM_PORTS) - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SEL  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    item_t             item_reg;
    logic [AGE_W-1:0]  age_limit_reg;
    cell_chain_t       sum_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    cell_cmd_t         cmd;
    cell_chain_t       chain [0:TABLE_DEPTH];
    logic              go;
    logic              full;
    logic              known;
    logic [PORT_W-1:0] dest_port;
    logic [MASK_W-1:0] dest_bit;
    logic [MASK_W-1:0] in_bit;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Advance through the update only when the output register is free or being read
    assign go   = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);
    assign full = !sum_reg.free_seen;

    // Row of entry cells
    assign chain[0] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        mlft_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Sequence the item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_SEL;
            ST_SEL:  state_next = ST_UPD;
            ST_UPD:  if (go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Build the command broadcast to the cells
    always_comb
    begin
        cmd.op        = OP_NOP;
        cmd.src_mac   = item_reg.src_mac;
        cmd.dst_mac   = item_reg.dst_mac;
        cmd.port      = item_reg.in_port;
        cmd.is_static = 1'b0;
        cmd.age       = '0;
        cmd.age_limit = age_limit_reg;
        unique case (state_reg)
            ST_CMP: cmd.op = OP_CMP;
            ST_SEL: cmd.op = OP_SEL;
            ST_UPD:
            begin
                if (go)
                begin
                    unique case (item_reg.kind)
                        KIND_FRAME:
                        begin
                            if (sum_reg.src_hit)
                                cmd.op = OP_MOVE;
                            else if (!full)
                                cmd.op = OP_ADD;
                        end
                        KIND_AGE:
                            cmd.op = OP_AGE;
                        KIND_ADD:
                        begin
                            cmd.is_static = item_reg.entry_static;
                            cmd.age       = item_reg.start_age;
                            if (!sum_reg.src_hit && !full)
                                cmd.op = OP_ADD;
                        end
                        KIND_DEL:
                        begin
                            if (sum_reg.src_hit)
                                cmd.op = OP_DEL;
                        end
                        default:
                            cmd.op = OP_NOP;
                    endcase
                end
            end
            default: cmd.op = OP_NOP;
        endcase
    end

    // Resolve the destination; a frame to itself sees its own fresh entry
    always_comb
    begin
        if (item_reg.dst_mac == item_reg.src_mac)
        begin
            known     = sum_reg.src_hit || !full;
            dest_port = (sum_reg.src_hit && sum_reg.src_static) ?
                        sum_reg.src_port : item_reg.in_port;
        end
        else
        begin
            known     = sum_reg.dst_hit;
            dest_port = sum_reg.dst_port;
        end
        dest_bit = MASK_W'(1) << dest_port;
        in_bit   = MASK_W'(1) << item_reg.in_port;
    end

    // Form the result
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (go)
        begin
            out_valid_next      = 1'b1;
            out_next.fwd_mask   = '0;
            out_next.dest_known = 1'b0;
            out_next.status     = STATUS_OK;
            unique case (item_reg.kind)
                KIND_FRAME:
                begin
                    out_next.dest_known = known;
                    if (!sum_reg.src_hit && full)
                        out_next.status = STATUS_FULL;
                    if (known)
                        out_next.fwd_mask = (dest_port != item_reg.in_port) ?
                                            (dest_bit & item_reg.link_up_mask) : '0;
                    else
                        out_next.fwd_mask = FLOOD_ALL & item_reg.link_up_mask & ~in_bit;
                end
                KIND_AGE:
                    out_next.status = STATUS_OK;
                KIND_ADD:
                begin
                    if (sum_reg.src_hit)
                        out_next.status = STATUS_PRESENT;
                    else if (full)
                        out_next.status = STATUS_FULL;
                end
                KIND_DEL:
                begin
                    if (!sum_reg.src_hit)
                        out_next.status = STATUS_NOT_FOUND;
                end
                default:
                    out_next.status = STATUS_OK;
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                age_limit_reg <= cfg_data;
        end
    end

    // Capture the item, the row summary and the result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
        if (state_reg == ST_SEL)
            sum_reg <= chain[TABLE_DEPTH];
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
